[rtl/bleadv_pkg.sv]
// bleadv_pkg: shared types, constants and bit-level helpers of the advertising packet framer
`timescale 1ns / 1ps

package bleadv_pkg;

  // payload length limits: AdvA octets plus at most MAX_ADV_DATA data octets
  localparam int          MAX_ADV_DATA = 31;
  localparam int          ADVA_OCTETS  = 6;
  localparam logic [5:0]  LEN_MIN      = 6'(ADVA_OCTETS);
  localparam logic [5:0]  LEN_MAX      = 6'(ADVA_OCTETS + MAX_ADV_DATA);
  localparam logic [5:0]  CNT_SAT      = 6'h3F;

  // crc-24 feedback taps without the x^0 term, which comes in through the shift
  localparam logic [23:0] CRC_TAPS     = 24'h00065A;

  // pdu type codes with special handling
  localparam logic [2:0]  TYPE_ADV_IND  = 3'd0;
  localparam logic [2:0]  TYPE_SCAN_RSP = 3'd4;
  localparam logic [2:0]  TYPE_SCAN_IND = 3'd6;
  localparam logic [2:0]  TYPE_UNDEF    = 3'd7;

  // register reset values
  localparam logic [7:0]  RST_PREAMBLE  = 8'hAA;
  localparam logic [31:0] RST_ACC_ADDR  = 32'h8E89BED6;
  localparam logic [23:0] RST_CRC_INIT  = 24'h555555;
  localparam logic [5:0]  RST_CHANNEL   = 6'd37;
  localparam logic [2:0]  RST_PDU_TYPE  = TYPE_ADV_IND;
  localparam logic [5:0]  RST_PAY_LEN   = 6'd6;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_PREAMBLE = 3'd0,
    CFG_ACC_ADDR = 3'd1,
    CFG_CRC_INIT = 3'd2,
    CFG_CHANNEL  = 3'd3,
    CFG_PDU_TYPE = 3'd4,
    CFG_TX_RAND  = 3'd5,
    CFG_RX_RAND  = 3'd6,
    CFG_PAY_LEN  = 3'd7
  } cfg_idx_t;

  // configuration register file contents
  typedef struct packed {
    logic [7:0]  preamble;
    logic [31:0] access_address;
    logic [23:0] crc_init;
    logic [5:0]  channel;
    logic [2:0]  pdu_type;
    logic        tx_addr_random;
    logic        rx_addr_random;
    logic [5:0]  payload_length;
  } cfg_t;

  // one payload word as held in the input stage
  typedef struct packed {
    logic [7:0] payload_octet;
    logic       last_octet;
  } item_t;

  // input stage status seen by the engine
  typedef struct packed {
    logic  valid;
    item_t item;
  } hold_t;

  // air phases of one packet
  typedef enum logic [3:0] {
    PH_PRE,
    PH_AA0,
    PH_AA1,
    PH_AA2,
    PH_AA3,
    PH_HDR0,
    PH_HDR1,
    PH_PAY,
    PH_CRC0,
    PH_CRC1,
    PH_CRC2
  } phase_t;

  typedef struct packed {
    logic [6:0] wh;
    logic [7:0] oct;
  } wh_res_t;

  typedef struct packed {
    logic [23:0] crc;
    logic [6:0]  wh;
    logic [7:0]  oct;
  } pdu_res_t;

  // crc register preset: octets of the init value in reverse order
  function automatic logic [23:0] crc_preset(logic [23:0] v);
    return {v[7:0], v[15:8], v[23:16]};
  endfunction

  // whitening seed: bit 0 set, channel bits 5..0 in bits 1..6
  function automatic logic [6:0] whiten_seed(logic [5:0] ch);
    return {ch[0], ch[1], ch[2], ch[3], ch[4], ch[5], 1'b1};
  endfunction

  // eight whitening steps, bit 0 first
  function automatic wh_res_t whiten_octet(logic [6:0] w_in, logic [7:0] d);
    logic [6:0] w;
    logic [7:0] o;
    logic       b6;
    wh_res_t    r;
    w = w_in;
    o = '0;
    for (int b = 0; b < 8; b++) begin
      b6   = w[6];
      o[b] = d[b] ^ b6;
      w    = {w[5:0], b6};
      w[4] = w[4] ^ b6;
    end
    r.wh  = w;
    r.oct = o;
    return r;
  endfunction

  // header or payload octet: eight crc steps plus whitening
  function automatic pdu_res_t pdu_octet(logic [23:0] crc_in, logic [6:0] w_in,
                                         logic [7:0] d);
    logic [23:0] c;
    logic        nb;
    wh_res_t     wr;
    pdu_res_t    r;
    c = crc_in;
    for (int b = 0; b < 8; b++) begin
      nb = c[23] ^ d[b];
      c  = {c[22:0], nb} ^ (nb ? CRC_TAPS : 24'h0);
    end
    wr    = whiten_octet(w_in, d);
    r.crc = c;
    r.wh  = wr.wh;
    r.oct = wr.oct;
    return r;
  endfunction

  // first header octet from type and address flags
  function automatic logic [7:0] header_octet0(logic [2:0] ptype, logic tx, logic rx);
    logic [2:0] t;
    logic       rxa;
    t   = (ptype == TYPE_UNDEF) ? TYPE_ADV_IND : ptype;
    rxa = (ptype == TYPE_SCAN_RSP) ? 1'b1 : rx;
    return {rxa, tx, 3'b000, t};
  endfunction

  function automatic logic [7:0] bit_rev8(logic [7:0] v);
    return {v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7]};
  endfunction

endpackage

[rtl/bleadv_cfg_regs.sv]
// bleadv_cfg_regs: configuration register file with write-only access
`timescale 1ns / 1ps

module bleadv_cfg_regs (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_wdata,
  output bleadv_pkg::cfg_t   cfg
);
  import bleadv_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // register write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      case (cfg_idx_t'(cfg_index))
        CFG_PREAMBLE: cfg_nxt.preamble       = cfg_wdata[7:0];
        CFG_ACC_ADDR: cfg_nxt.access_address = cfg_wdata;
        CFG_CRC_INIT: cfg_nxt.crc_init       = cfg_wdata[23:0];
        CFG_CHANNEL:  cfg_nxt.channel        = cfg_wdata[5:0];
        CFG_PDU_TYPE: cfg_nxt.pdu_type       = cfg_wdata[2:0];
        CFG_TX_RAND:  cfg_nxt.tx_addr_random = cfg_wdata[0];
        CFG_RX_RAND:  cfg_nxt.rx_addr_random = cfg_wdata[0];
        CFG_PAY_LEN:  cfg_nxt.payload_length = cfg_wdata[5:0];
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.preamble       <= RST_PREAMBLE;
      cfg_r.access_address <= RST_ACC_ADDR;
      cfg_r.crc_init       <= RST_CRC_INIT;
      cfg_r.channel        <= RST_CHANNEL;
      cfg_r.pdu_type       <= RST_PDU_TYPE;
      cfg_r.tx_addr_random <= 1'b0;
      cfg_r.rx_addr_random <= 1'b0;
      cfg_r.payload_length <= RST_PAY_LEN;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

[rtl/bleadv_in_stage.sv]
// bleadv_in_stage: one-word input register in front of the framing engine
`timescale 1ns / 1ps

module bleadv_in_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [7:0]         in_tdata,
  input  logic               in_tlast,
  input  logic               consume,
  output bleadv_pkg::hold_t  hold
);
  import bleadv_pkg::*;

  logic  hold_v_r;
  logic  hold_v_nxt;
  item_t item_r;
  logic  in_acc;

  // free when empty or when the engine takes the held word this cycle
  assign in_tready = !hold_v_r || consume;
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    hold_v_nxt = hold_v_r;
    if (in_acc) begin
      hold_v_nxt = 1'b1;
    end else if (consume) begin
      hold_v_nxt = 1'b0;
    end
  end

  // valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
    end else begin
      hold_v_r <= hold_v_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (in_acc) begin
      item_r.payload_octet <= in_tdata;
      item_r.last_octet    <= in_tlast;
    end
  end

  assign hold.valid = hold_v_r;
  assign hold.item  = item_r;

endmodule

[rtl/bleadv_engine.sv]
// bleadv_engine: phase sequencer, crc-24 and whitening, output register
`timescale 1ns / 1ps

module bleadv_engine (
  input  logic               clk,
  input  logic               rst_n,
  input  bleadv_pkg::cfg_t   cfg,
  input  bleadv_pkg::hold_t  hold,
  output logic               consume,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [7:0]         out_tdata,
  output logic               out_tlast,
  output logic               out_tuser
);
  import bleadv_pkg::*;

  phase_t      ph_r, ph_nxt;
  logic [23:0] crc_r, crc_nxt;
  logic [6:0]  wh_r, wh_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        mis_r, mis_nxt;
  logic        out_v_r, out_v_nxt;
  logic [7:0]  out_oct_r, oct_nxt;
  logic        out_eop_r, eop_nxt;
  logic        out_mis_r, omis_nxt;

  logic        out_free;
  logic        need_item;
  logic        fire;
  logic [5:0]  cnt_inc;
  pdu_res_t    pdu;
  wh_res_t     whr;
  logic [7:0]  pdu_in;

  // one air word per cycle whenever the output register has room and, outside the crc phases, a word is held
  assign out_free  = !out_v_r || out_tready;
  assign need_item = (ph_r != PH_CRC0) && (ph_r != PH_CRC1) && (ph_r != PH_CRC2);
  assign fire      = out_free && (!need_item || hold.valid);
  assign consume   = fire && (ph_r == PH_PAY);

  // next phase
  always_comb begin
    ph_nxt = ph_r;
    if (fire) begin
      case (ph_r)
        PH_PRE:  ph_nxt = PH_AA0;
        PH_AA0:  ph_nxt = PH_AA1;
        PH_AA1:  ph_nxt = PH_AA2;
        PH_AA2:  ph_nxt = PH_AA3;
        PH_AA3:  ph_nxt = PH_HDR0;
        PH_HDR0: ph_nxt = PH_HDR1;
        PH_HDR1: ph_nxt = PH_PAY;
        PH_PAY:  ph_nxt = hold.item.last_octet ? PH_CRC0 : PH_PAY;
        PH_CRC0: ph_nxt = PH_CRC1;
        PH_CRC1: ph_nxt = PH_CRC2;
        PH_CRC2: ph_nxt = PH_PRE;
        default: ph_nxt = PH_PRE;
      endcase
    end
  end

  // shared pdu octet unit: header octets and payload
  always_comb begin
    case (ph_r)
      PH_HDR0: pdu_in = header_octet0(cfg.pdu_type, cfg.tx_addr_random,
                                      cfg.rx_addr_random);
      PH_HDR1: pdu_in = {2'b00, cfg.payload_length};
      default: pdu_in = hold.item.payload_octet;
    endcase
  end

  assign pdu     = pdu_octet(crc_r, wh_r, pdu_in);
  assign cnt_inc = (cnt_r == CNT_SAT) ? cnt_r : cnt_r + 6'd1;

  // crc words: register bits taken top down, whitened
  always_comb begin
    case (ph_r)
      PH_CRC0: whr = whiten_octet(wh_r, bit_rev8(crc_r[23:16]));
      PH_CRC1: whr = whiten_octet(wh_r, bit_rev8(crc_r[15:8]));
      default: whr = whiten_octet(wh_r, bit_rev8(crc_r[7:0]));
    endcase
  end

  // word contents and datapath updates per phase
  always_comb begin
    crc_nxt  = crc_r;
    wh_nxt   = wh_r;
    cnt_nxt  = cnt_r;
    mis_nxt  = mis_r;
    oct_nxt  = out_oct_r;
    eop_nxt  = out_eop_r;
    omis_nxt = out_mis_r;
    out_v_nxt = out_v_r && !out_tready;
    if (fire) begin
      out_v_nxt = 1'b1;
      eop_nxt   = 1'b0;
      omis_nxt  = 1'b0;
      case (ph_r)
        PH_PRE: begin
          oct_nxt = cfg.preamble;
          crc_nxt = crc_preset(cfg.crc_init);
          wh_nxt  = whiten_seed(cfg.channel);
          cnt_nxt = '0;
        end
        PH_AA0: oct_nxt = cfg.access_address[31:24];
        PH_AA1: oct_nxt = cfg.access_address[23:16];
        PH_AA2: oct_nxt = cfg.access_address[15:8];
        PH_AA3: oct_nxt = cfg.access_address[7:0];
        PH_HDR0, PH_HDR1: begin
          oct_nxt = pdu.oct;
          crc_nxt = pdu.crc;
          wh_nxt  = pdu.wh;
        end
        PH_PAY: begin
          oct_nxt = pdu.oct;
          crc_nxt = pdu.crc;
          wh_nxt  = pdu.wh;
          cnt_nxt = cnt_inc;
          mis_nxt = (cnt_inc != cfg.payload_length) || (cnt_inc < LEN_MIN) ||
                    (cnt_inc > LEN_MAX);
        end
        PH_CRC0, PH_CRC1: begin
          oct_nxt = whr.oct;
          wh_nxt  = whr.wh;
        end
        PH_CRC2: begin
          oct_nxt  = whr.oct;
          wh_nxt   = whr.wh;
          eop_nxt  = 1'b1;
          omis_nxt = mis_r;
          cnt_nxt  = '0;
        end
        default: oct_nxt = out_oct_r;
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r    <= PH_PRE;
      out_v_r <= 1'b0;
      cnt_r   <= '0;
    end else begin
      ph_r    <= ph_nxt;
      out_v_r <= out_v_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // datapath registers, loaded at packet start before use
  always_ff @(posedge clk) begin
    crc_r     <= crc_nxt;
    wh_r      <= wh_nxt;
    mis_r     <= mis_nxt;
    out_oct_r <= oct_nxt;
    out_eop_r <= eop_nxt;
    out_mis_r <= omis_nxt;
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_oct_r;
  assign out_tlast  = out_eop_r;
  assign out_tuser  = out_mis_r;

endmodule

[rtl/ble_adv_packet_framer_core.sv]
// ble_adv_packet_framer_core: top level of the advertising packet framer
//
//   channel   dir  handshake          tdata                tlast          tuser
//   in_       in   in_tvalid/tready   [7:0] payload_octet  last_octet     -
//   out_      out  out_tvalid/tready  [7:0] air_octet      end_of_packet  length_mismatch
//   cfg_      in   cfg_wr_en          cfg_wdata[31:0] at register cfg_index[2:0]
//
// one air word leaves per cycle unless stalled or short of input; the first word of
// a packet gives eight (preamble, access address, two header words, payload), the
// last four, others one; a mid-packet word passes the input and output registers
// reset is synchronous, active low, and clears the phase, valid flags and count
// an output stall holds the output register; one word waits in the input stage
// during header and crc bursts
`timescale 1ns / 1ps

module ble_adv_packet_framer_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] payload_octet
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] air_octet
  output logic        out_tlast,
  output logic        out_tuser,  // [0] length_mismatch
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);
  import bleadv_pkg::*;

  cfg_t  cfg;
  hold_t hold;
  logic  consume;

  // configuration registers
  bleadv_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // input register
  bleadv_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .consume   (consume),
    .hold      (hold)
  );

  // framing engine and output register
  bleadv_engine u_eng (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .hold       (hold),
    .consume    (consume),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

[rtl/bleadv_checker.sv]
// bleadv_checker: port-level assertions for the framer, bound to the top level
`timescale 1ns / 1ps

module bleadv_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [7:0]  out_tdata,
  input logic        out_tlast,
  input logic        out_tuser
);

  // stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
                                  $stable(out_tlast) && $stable(out_tuser))
    else $error("output word changed while stalled");

  // mismatch flag only rides on the end of packet word
  a_mis_eop: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast)
    else $error("length mismatch outside end of packet");

  // word after an end of packet is a preamble, never another end
  a_eop_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tlast |=> !(out_tvalid && out_tlast))
    else $error("two end of packet words in a row");

  // nothing on the output right after reset
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // input stage is empty right after reset
  a_rst_ready: assert property (@(posedge clk)
    !rst_n |=> in_tready)
    else $error("input not ready after reset");

endmodule

bind ble_adv_packet_framer_core bleadv_checker u_bleadv_chk (.*);

[test/adv_frame_checker.sv]
// adv_frame_checker: watches the framer's ports, predicts every air word and compares
`timescale 1ns / 1ps

module adv_frame_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        in_tlast,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [7:0]  out_tdata,
  input  logic        out_tlast,
  input  logic        out_tuser,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  output int          err_count,
  output int          pending,
  output int          words_checked,
  output int          frames_checked
);
  import bleadv_pkg::*;

  // crc-24 feedback taps, x^0 enters through the shift
  localparam logic [23:0] CRC_POLY = 24'h00065A;

  typedef struct packed {
    logic [7:0] air;
    logic       eop;
    logic       mis;
  } air_word_t;

  // register copies
  logic [7:0]  preamble_r;
  logic [31:0] acc_addr_r;
  logic [23:0] crc_init_r;
  logic [5:0]  chan_r;
  logic [2:0]  ptype_r;
  logic        tx_rand_r;
  logic        rx_rand_r;
  logic [5:0]  pay_len_r;

  // framing state
  logic [23:0] crc_reg;
  logic [6:0]  wht_reg;
  logic [5:0]  pay_count;
  logic        in_frame;

  air_word_t   air_q[$];
  int          errs;
  int          n_words;
  int          n_frames;

  // one whitening step
  task automatic whiten(input logic din, output logic dout);
    logic fb;
    fb      = wht_reg[6];
    dout    = din ^ fb;
    wht_reg = {wht_reg[5:0], fb};
    wht_reg[4] = wht_reg[4] ^ fb;
  endtask

  // header or payload octet: crc and whitening, lsb first
  task automatic pdu_code(input logic [7:0] d, output logic [7:0] o);
    logic fb;
    logic ob;
    for (int b = 0; b < 8; b++) begin
      fb      = crc_reg[23] ^ d[b];
      crc_reg = {crc_reg[22:0], fb} ^ (fb ? CRC_POLY : 24'h0);
      whiten(d[b], ob);
      o[b] = ob;
    end
  endtask

  task automatic push_air(input logic [7:0] a, input logic e, input logic m);
    air_word_t w;
    w.air = a;
    w.eop = e;
    w.mis = m;
    air_q.insert(air_q.size(), w);
  endtask

  // expected air words for one accepted payload word
  task automatic frame_octet(input logic [7:0] d, input logic l);
    logic [7:0]  h0;
    logic [7:0]  o;
    logic [2:0]  ty;
    logic        rxa;
    logic        bad;
    logic        ob;
    logic [23:0] snap;
    if (!in_frame) begin
      ty  = ptype_r;
      rxa = rx_rand_r;
      if (ty == TYPE_UNDEF) ty = TYPE_ADV_IND;
      if (ty == TYPE_SCAN_RSP) rxa = 1'b1;
      h0 = {rxa, tx_rand_r, 3'b000, ty};
      crc_reg = {crc_init_r[7:0], crc_init_r[15:8], crc_init_r[23:16]};
      wht_reg[0] = 1'b1;
      for (int k = 1; k <= 6; k++) wht_reg[k] = chan_r[6-k];
      pay_count = '0;
      in_frame  = 1'b1;
      push_air(preamble_r, 1'b0, 1'b0);
      for (int i = 0; i < 4; i++) push_air(acc_addr_r[31-8*i -: 8], 1'b0, 1'b0);
      pdu_code(h0, o);
      push_air(o, 1'b0, 1'b0);
      pdu_code({2'b00, pay_len_r}, o);
      push_air(o, 1'b0, 1'b0);
    end
    pdu_code(d, o);
    push_air(o, 1'b0, 1'b0);
    if (pay_count != CNT_SAT) pay_count = pay_count + 6'd1;
    // crc tail from the register top bit down
    if (l) begin
      bad  = (pay_count != pay_len_r) || (pay_count < LEN_MIN) || (pay_count > LEN_MAX);
      snap = crc_reg;
      for (int k = 0; k < 3; k++) begin
        for (int b = 0; b < 8; b++) begin
          whiten(snap[23-(8*k+b)], ob);
          o[b] = ob;
        end
        push_air(o, k == 2, (k == 2) ? bad : 1'b0);
      end
      in_frame  = 1'b0;
      pay_count = '0;
    end
  endtask

  always @(posedge clk) begin : watch
    air_word_t w;
    if (!rst_n) begin
      preamble_r = RST_PREAMBLE;
      acc_addr_r = RST_ACC_ADDR;
      crc_init_r = RST_CRC_INIT;
      chan_r     = RST_CHANNEL;
      ptype_r    = RST_PDU_TYPE;
      tx_rand_r  = 1'b0;
      rx_rand_r  = 1'b0;
      pay_len_r  = RST_PAY_LEN;
      in_frame   = 1'b0;
      pay_count  = '0;
      air_q.delete();
    end else begin
      // register writes
      if (cfg_wr_en) begin
        case (cfg_idx_t'(cfg_index))
          CFG_PREAMBLE: preamble_r = cfg_wdata[7:0];
          CFG_ACC_ADDR: acc_addr_r = cfg_wdata;
          CFG_CRC_INIT: crc_init_r = cfg_wdata[23:0];
          CFG_CHANNEL:  chan_r     = cfg_wdata[5:0];
          CFG_PDU_TYPE: ptype_r    = cfg_wdata[2:0];
          CFG_TX_RAND:  tx_rand_r  = cfg_wdata[0];
          CFG_RX_RAND:  rx_rand_r  = cfg_wdata[0];
          CFG_PAY_LEN:  pay_len_r  = cfg_wdata[5:0];
          default: ;
        endcase
      end
      // accepted payload word
      if (in_tvalid && in_tready) frame_octet(in_tdata, in_tlast);
      // accepted air word against the oldest expectation
      if (out_tvalid && out_tready) begin
        if (air_q.size() == 0) begin
          $error("air word %02h arrived with nothing expected", out_tdata);
          errs++;
        end else begin
          w = air_q.pop_front();
          n_words++;
          if (w.eop) n_frames++;
          if (out_tdata !== w.air) begin
            $error("air_octet: expected %02h, got %02h", w.air, out_tdata);
            errs++;
          end
          if (out_tlast !== w.eop) begin
            $error("end_of_packet: expected %0b, got %0b", w.eop, out_tlast);
            errs++;
          end
          if (out_tuser !== w.mis) begin
            $error("length_mismatch: expected %0b, got %0b", w.mis, out_tuser);
            errs++;
          end
        end
      end
    end
    pending        <= air_q.size();
    err_count      <= errs;
    words_checked  <= n_words;
    frames_checked <= n_frames;
  end

  initial begin
    errs     = 0;
    n_words  = 0;
    n_frames = 0;
  end

endmodule

[test/tb.sv]
// tb: stimulus, reset, flow control and verdict for the advertising packet framer
`timescale 1ns / 1ps

module tb;
  import bleadv_pkg::*;

  localparam int RAND_ITEMS = 240;
  localparam int IDLE_LIMIT = 2000;

  // payload fill patterns
  typedef enum int {
    FILL_RAND,
    FILL_ZERO,
    FILL_ONES,
    FILL_ALT
  } fill_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = '0;
  logic        in_tlast   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic        out_tlast;
  logic        out_tuser;
  logic        cfg_wr_en  = 1'b0;
  logic [2:0]  cfg_index  = '0;
  logic [31:0] cfg_wdata  = '0;

  int err_count;
  int pending;
  int words_checked;
  int frames_checked;

  int burst_left = 0;
  int words_sent = 0;
  int settings   = 1;
  int idle_cyc   = 0;
  int rx_cyc     = 0;

  ble_adv_packet_framer_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  adv_frame_checker u_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tlast       (in_tlast),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tlast      (out_tlast),
    .out_tuser      (out_tuser),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .err_count      (err_count),
    .pending        (pending),
    .words_checked  (words_checked),
    .frames_checked (frames_checked)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // receiver back-pressure: free run, light random, periodic, heavy random
  always @(posedge clk) begin
    rx_cyc <= rx_cyc + 1;
    case (rx_cyc[8:7])
      2'd0: out_tready <= 1'b1;
      2'd1: out_tready <= ($urandom_range(0, 3) != 0);
      2'd2: out_tready <= (rx_cyc[2:0] != 3'd5);
      default: out_tready <= 1'($urandom_range(0, 1));
    endcase
  end

  // watchdog on cycles where no word moves
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_wr_en)
      idle_cyc <= 0;
    else
      idle_cyc <= idle_cyc + 1;
    if (idle_cyc == IDLE_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles, %0d air words outstanding",
               IDLE_LIMIT, pending);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // one payload word, then maybe a gap between bursts
  task automatic put_word(input logic [7:0] d, input logic l);
    int gap;
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    in_tlast  <= l;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    words_sent++;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  // one packet of n payload words in the given fill pattern
  task automatic send_packet(input int n, input fill_t fill);
    logic [7:0] d;
    for (int i = 0; i < n; i++) begin
      case (fill)
        FILL_ZERO: d = 8'h00;
        FILL_ONES: d = 8'hFF;
        FILL_ALT:  d = i[0] ? 8'hAA : 8'h55;
        default:   d = 8'($urandom_range(0, 255));
      endcase
      put_word(d, i == n - 1);
    end
  endtask

  // stop sending, wait until every air word is out, then let the pipeline settle
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [31:0] v);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
  endtask

  task automatic program_cfg(input cfg_t s);
    write_reg(CFG_PREAMBLE, {24'h0, s.preamble});
    write_reg(CFG_ACC_ADDR, s.access_address);
    write_reg(CFG_CRC_INIT, {8'h0, s.crc_init});
    write_reg(CFG_CHANNEL,  {26'h0, s.channel});
    write_reg(CFG_PDU_TYPE, {29'h0, s.pdu_type});
    write_reg(CFG_TX_RAND,  {31'h0, s.tx_addr_random});
    write_reg(CFG_RX_RAND,  {31'h0, s.rx_addr_random});
    write_reg(CFG_PAY_LEN,  {26'h0, s.payload_length});
    cfg_wr_en <= 1'b0;
    settings++;
  endtask

  initial begin : stim
    cfg_t s;
    int   n;
    int   r;
    int   rand_words;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: matching length, then a packet whose first word is also last
    send_packet(6, FILL_ZERO);
    send_packet(1, FILL_ONES);

    // all-ones settings: undefined type, channel past 39, short count
    wait_idle();
    s.preamble       = 8'hFF;
    s.access_address = 32'hFFFF_FFFF;
    s.crc_init       = 24'hFF_FFFF;
    s.channel        = 6'd63;
    s.pdu_type       = TYPE_UNDEF;
    s.tx_addr_random = 1'b1;
    s.rx_addr_random = 1'b1;
    s.payload_length = 6'd63;
    program_cfg(s);
    send_packet(5, FILL_ALT);

    // all-zero fields, scan response forces the rx address flag
    wait_idle();
    s = '0;
    s.pdu_type       = TYPE_SCAN_RSP;
    s.payload_length = LEN_MAX;
    program_cfg(s);
    send_packet(6, FILL_RAND);

    // highest valid channel, last defined type, matching length
    wait_idle();
    s.preamble       = RST_PREAMBLE;
    s.access_address = RST_ACC_ADDR;
    s.crc_init       = 24'h123456;
    s.channel        = 6'd39;
    s.pdu_type       = TYPE_SCAN_IND;
    s.tx_addr_random = 1'b0;
    s.rx_addr_random = 1'b1;
    s.payload_length = 6'd7;
    program_cfg(s);
    send_packet(7, FILL_RAND);

    // random settings, three packets each, mostly with the announced length
    rand_words = 0;
    while (rand_words < RAND_ITEMS) begin
      wait_idle();
      s.preamble       = 8'($urandom_range(0, 255));
      s.access_address = $urandom;
      s.crc_init       = 24'($urandom_range(0, 24'hFF_FFFF));
      s.channel        = 6'(($urandom_range(0, 9) == 0) ? $urandom_range(40, 63)
                                                        : $urandom_range(0, 39));
      s.pdu_type       = 3'($urandom_range(0, 7));
      s.tx_addr_random = 1'($urandom_range(0, 1));
      s.rx_addr_random = 1'($urandom_range(0, 1));
      r = $urandom_range(0, 9);
      if (r < 8)       s.payload_length = 6'($urandom_range(6, 14));
      else if (r == 8) s.payload_length = LEN_MAX;
      else             s.payload_length = 6'($urandom_range(0, 63));
      program_cfg(s);
      for (int p = 0; p < 3; p++) begin
        r = $urandom_range(0, 99);
        if (r < 70 && s.payload_length != 0) n = int'(s.payload_length);
        else if (r < 96)                     n = $urandom_range(1, 40);
        else                                 n = $urandom_range(60, 68);
        send_packet(n, FILL_RAND);
        rand_words += n;
      end
    end

    in_tvalid <= 1'b0;
    wait_idle();
    repeat (10) @(posedge clk);

    $display("run: %0d payload words sent in %0d packets under %0d register settings",
             words_sent, frames_checked, settings);
    $display("run: %0d air words compared field by field", words_checked);
    if (err_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
